// ===== hdl/tkd_pkg.sv =====
// Shared types, byte codes and decode functions for the terminal key sequence decoder.
package tkd_pkg;

  // Parser position inside an escape sequence or a multibyte character
  typedef enum logic [3:0] {
    MODE_IDLE,
    MODE_ESC,
    MODE_CSI,
    MODE_ONE,
    MODE_MOD1,
    MODE_FIN1,
    MODE_TILDE,
    MODE_TMOD,
    MODE_TFIN,
    MODE_UTF8
  } mode_t;

  // Decoded key kinds
  typedef enum logic [3:0] {
    KEY_CHAR  = 4'd0,
    KEY_UNKN  = 4'd1,
    KEY_UP    = 4'd2,
    KEY_DOWN  = 4'd3,
    KEY_RIGHT = 4'd4,
    KEY_LEFT  = 4'd5,
    KEY_END   = 4'd6,
    KEY_HOME  = 4'd7,
    KEY_ENTER = 4'd8,
    KEY_BKSP  = 4'd9,
    KEY_DEL   = 4'd10,
    KEY_TAB   = 4'd11,
    KEY_INTR  = 4'd12
  } key_t;

  // Modifier bits: bit 0 ctrl, bit 1 shift
  typedef logic [1:0] mods_t;
  localparam mods_t MOD_NONE  = 2'b00;
  localparam mods_t MOD_CTRL  = 2'b01;
  localparam mods_t MOD_SHIFT = 2'b10;

  // Byte codes
  localparam logic [7:0] CH_ETX     = 8'd3;
  localparam logic [7:0] CH_BS      = 8'd8;
  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_LF      = 8'd10;
  localparam logic [7:0] CH_CR      = 8'd13;
  localparam logic [7:0] CH_ETB     = 8'd23;
  localparam logic [7:0] CH_ESC     = 8'd27;
  localparam logic [7:0] CH_ONE     = 8'd49;
  localparam logic [7:0] CH_TWO     = 8'd50;
  localparam logic [7:0] CH_THREE   = 8'd51;
  localparam logic [7:0] CH_FIVE    = 8'd53;
  localparam logic [7:0] CH_SEMI    = 8'd59;
  localparam logic [7:0] CH_A       = 8'd65;
  localparam logic [7:0] CH_B       = 8'd66;
  localparam logic [7:0] CH_C       = 8'd67;
  localparam logic [7:0] CH_D       = 8'd68;
  localparam logic [7:0] CH_F       = 8'd70;
  localparam logic [7:0] CH_H       = 8'd72;
  localparam logic [7:0] CH_BRACKET = 8'd91;
  localparam logic [7:0] CH_TILDE   = 8'd126;
  localparam logic [7:0] CH_RUBOUT  = 8'd127;

  // Modifier digit of a sequence
  function automatic mods_t mod_of(input logic [7:0] b);
    mods_t m;
    m = MOD_NONE;
    if (b == CH_TWO) m = MOD_SHIFT;
    else if (b == CH_FIVE) m = MOD_CTRL;
    return m;
  endfunction

  // Final byte of a sequence to key kind
  function automatic key_t final_key(input logic [7:0] b);
    key_t k;
    unique case (b)
      CH_THREE: k = KEY_DEL;
      CH_A:     k = KEY_UP;
      CH_B:     k = KEY_DOWN;
      CH_C:     k = KEY_RIGHT;
      CH_D:     k = KEY_LEFT;
      CH_F:     k = KEY_END;
      CH_H:     k = KEY_HOME;
      default:  k = KEY_UNKN;
    endcase
    return k;
  endfunction

  // UTF-8 character length from its lead byte, 0 when not a lead
  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] n;
    if ((b & 8'h80) == 8'h00) n = 3'd1;
    else if ((b & 8'hE0) == 8'hC0) n = 3'd2;
    else if ((b & 8'hF0) == 8'hE0) n = 3'd3;
    else if ((b & 8'hF8) == 8'hF0) n = 3'd4;
    else n = 3'd0;
    return n;
  endfunction

endpackage

// ===== hdl/terminal_key_sequence_decoder.sv =====
// Terminal key sequence decoder: byte parser state and registered key event output.
//
// Takes one terminal byte per word and emits one key event word when a control
// byte, an escape sequence or a UTF-8 character completes, or on a byte that cannot
// lead. Each byte is parsed combinationally by a small state machine; the event
// lands in an output register, so a byte can be accepted every clock unless
// in_stall is high. in_stall rises only while a finished event sits in the output
// register and out_stall holds it there. Bytes that only advance a sequence give no output word.
module terminal_key_sequence_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  key_kind,
  output logic        ctrl_flag,
  output logic        shift_flag,
  output logic        alt_flag,
  output logic [31:0] char_bytes,
  output logic [2:0]  char_length
);
  import tkd_pkg::*;

  // Parser state
  mode_t       mode, mode_next;
  mods_t       pend_mods, pend_mods_next;
  key_t        pend_key, pend_key_next;
  logic [23:0] utf8_gather, utf8_gather_next;
  logic [7:0]  utf8_lead, utf8_lead_next;
  logic [1:0]  utf8_left, utf8_left_next;
  logic [2:0]  utf8_total, utf8_total_next;

  // Result of the current byte
  logic        emit;
  key_t        res_kind;
  mods_t       res_mods;
  logic        res_alt;
  logic [31:0] res_bytes;
  logic [2:0]  res_len;
  logic        run_idle;
  logic [1:0]  upos;
  logic [2:0]  lead_len;
  key_t        fin_key;
  logic        in_fire;

  assign in_stall = out_valid & out_stall;
  assign in_fire  = in_valid & ~in_stall;
  assign lead_len = lead_length(in_byte);
  assign fin_key  = final_key(in_byte);

  // Byte slot for a continuation byte: 1..3
  always_comb begin
    upos = utf8_total[1:0] - utf8_left;
    if (upos == 2'd0) upos = 2'd1;
  end

  // Next state and event decode
  always_comb begin
    mode_next        = mode;
    pend_mods_next   = pend_mods;
    pend_key_next    = pend_key;
    utf8_gather_next = utf8_gather;
    utf8_lead_next   = utf8_lead;
    utf8_left_next   = utf8_left;
    utf8_total_next  = utf8_total;
    emit      = 1'b0;
    res_kind  = KEY_CHAR;
    res_mods  = MOD_NONE;
    res_alt   = 1'b0;
    res_bytes = '0;
    res_len   = 3'd0;
    run_idle  = 1'b0;

    unique case (mode)
      MODE_ESC: begin
        if (in_byte != CH_BRACKET) begin
          emit      = 1'b1;
          res_alt   = 1'b1;
          res_bytes = {24'd0, in_byte};
          res_len   = 3'd1;
        end else begin
          mode_next = MODE_CSI;
        end
      end
      MODE_CSI: begin
        pend_mods_next = MOD_NONE;
        if (in_byte == CH_ONE) begin
          mode_next = MODE_ONE;
        end else if (fin_key == KEY_DEL || fin_key == KEY_UNKN) begin
          pend_key_next = fin_key;
          mode_next     = MODE_TILDE;
        end else begin
          emit     = 1'b1;
          res_kind = fin_key;
        end
      end
      MODE_ONE: begin
        if (in_byte != CH_SEMI) begin
          emit     = 1'b1;
          res_kind = KEY_UNKN;
        end else begin
          mode_next = MODE_MOD1;
        end
      end
      MODE_MOD1: begin
        pend_mods_next = mod_of(in_byte);
        mode_next      = MODE_FIN1;
      end
      MODE_FIN1: begin
        emit     = 1'b1;
        res_kind = fin_key;
        res_mods = pend_mods;
      end
      MODE_TILDE: begin
        if (in_byte == CH_SEMI) begin
          mode_next = MODE_TMOD;
        end else begin
          emit     = 1'b1;
          res_kind = (in_byte == CH_TILDE) ? pend_key : KEY_UNKN;
        end
      end
      MODE_TMOD: begin
        pend_mods_next = mod_of(in_byte);
        mode_next      = MODE_TFIN;
      end
      MODE_TFIN: begin
        emit = 1'b1;
        if (in_byte == CH_TILDE) begin
          res_kind = pend_key;
          res_mods = pend_mods;
        end else begin
          res_kind = KEY_UNKN;
        end
      end
      MODE_UTF8: begin
        case (upos)
          2'd2:    utf8_gather_next = utf8_gather | {8'd0, in_byte, 8'd0};
          2'd3:    utf8_gather_next = utf8_gather | {in_byte, 16'd0};
          default: utf8_gather_next = utf8_gather | {16'd0, in_byte};
        endcase
        utf8_left_next = utf8_left - 2'd1;
        if (utf8_left_next == 2'd0) begin
          emit      = 1'b1;
          res_bytes = {utf8_gather_next, utf8_lead};
          res_len   = utf8_total;
        end
      end
      default: run_idle = 1'b1;
    endcase

    // Start of a new word: control bytes, escape, a UTF-8 lead, or a byte that cannot lead
    if (run_idle) begin
      mode_next = MODE_IDLE;
      unique case (in_byte) inside
        CH_ETX: begin
          emit = 1'b1; res_kind = KEY_INTR;
        end
        CH_TAB: begin
          emit = 1'b1; res_kind = KEY_TAB;
        end
        CH_LF, CH_CR: begin
          emit = 1'b1; res_kind = KEY_ENTER;
        end
        CH_ETB: begin
          emit = 1'b1; res_kind = KEY_BKSP; res_mods = MOD_CTRL;
        end
        CH_BS, CH_RUBOUT: begin
          emit = 1'b1; res_kind = KEY_BKSP;
        end
        CH_ESC: mode_next = MODE_ESC;
        default: begin
          if (lead_len == 3'd0) begin
            emit = 1'b1;
          end else if (lead_len == 3'd1) begin
            emit      = 1'b1;
            res_bytes = {24'd0, in_byte};
            res_len   = 3'd1;
          end else begin
            utf8_lead_next   = in_byte;
            utf8_total_next  = lead_len;
            utf8_left_next   = 2'(lead_len - 3'd1);
            utf8_gather_next = '0;
            mode_next        = MODE_UTF8;
          end
        end
      endcase
    end

    if (emit) mode_next = MODE_IDLE;
  end

  // Parser state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_IDLE;
      pend_mods   <= MOD_NONE;
      pend_key    <= KEY_CHAR;
      utf8_gather <= '0;
      utf8_lead   <= '0;
      utf8_left   <= '0;
      utf8_total  <= '0;
    end else if (in_fire) begin
      mode        <= mode_next;
      pend_mods   <= pend_mods_next;
      pend_key    <= pend_key_next;
      utf8_gather <= utf8_gather_next;
      utf8_lead   <= utf8_lead_next;
      utf8_left   <= utf8_left_next;
      utf8_total  <= utf8_total_next;
    end
  end

  // Output word valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!in_stall) begin
      out_valid <= in_fire & emit;
    end
  end

  // Output word payload
  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      key_kind    <= res_kind;
      ctrl_flag   <= res_mods[0];
      shift_flag  <= res_mods[1];
      alt_flag    <= res_alt;
      char_bytes  <= res_bytes;
      char_length <= res_len;
    end
  end

endmodule

// ===== hdl/tkd_checker.sv =====
// Port-level assertions for the terminal key sequence decoder, with its bind.
module tkd_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [3:0]  key_kind,
  input logic        ctrl_flag,
  input logic        shift_flag,
  input logic        alt_flag,
  input logic [31:0] char_bytes,
  input logic [2:0]  char_length
);
  import tkd_pkg::*;

  // Input side backs up only behind a held output word
  assert property (@(posedge clk) disable iff (rst) in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held output word");

  // A held output word does not change
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(key_kind) && $stable(char_bytes)
      && $stable(char_length) && $stable(alt_flag))
    else $error("held output word changed");

  // Non-character keys carry no character bytes
  assert property (@(posedge clk) disable iff (rst)
    out_valid && key_kind != KEY_CHAR |-> char_length == 3'd0 && char_bytes == 32'd0
      && !alt_flag)
    else $error("key event carries character data");

  // Alt character is a single plain byte without modifiers
  assert property (@(posedge clk) disable iff (rst)
    out_valid && alt_flag |-> key_kind == KEY_CHAR && char_length == 3'd1
      && char_bytes[31:8] == 24'd0 && !ctrl_flag && !shift_flag)
    else $error("malformed alt character");

endmodule

bind terminal_key_sequence_decoder tkd_checker u_tkd_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(in_valid),
  .in_stall(in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .key_kind(key_kind),
  .ctrl_flag(ctrl_flag),
  .shift_flag(shift_flag),
  .alt_flag(alt_flag),
  .char_bytes(char_bytes),
  .char_length(char_length)
);

// ===== tb/tkd_key_event_monitor.sv =====
// Monitor for the terminal key sequence decoder: predicts key events and checks the output.
module tkd_key_event_monitor (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [3:0]  key_kind,
  input  logic        ctrl_flag,
  input  logic        shift_flag,
  input  logic        alt_flag,
  input  logic [31:0] char_bytes,
  input  logic [2:0]  char_length,
  output int          fail_count,
  output int          events_owed,
  output int          events_checked
);
  import tkd_pkg::*;

  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    key_t        kind;
    logic        ctrl;
    logic        shift;
    logic        alt;
    logic [31:0] bytes;
    logic [2:0]  len;
  } key_event_t;

  // Predicted key events, oldest first
  key_event_t owed_events[$];
  key_event_t seen;
  key_event_t want;

  // Shadow parser state
  mode_t       parse_pos;
  mods_t       held_mods;
  key_t        held_key;
  logic [23:0] utf8_tail;
  logic [7:0]  utf8_first;
  logic [1:0]  utf8_togo;
  logic [2:0]  utf8_size_total;

  initial begin
    fail_count = 0;
    events_owed = 0;
    events_checked = 0;
  end

  // Modifier digit: '2' shift, '5' ctrl, anything else nothing
  function automatic mods_t modifier_of(input logic [7:0] b);
    case (b)
      CH_TWO:  return MOD_SHIFT;
      CH_FIVE: return MOD_CTRL;
      default: return MOD_NONE;
    endcase
  endfunction

  function automatic key_t key_of_final(input logic [7:0] b);
    case (b)
      CH_THREE: return KEY_DEL;
      CH_A:     return KEY_UP;
      CH_B:     return KEY_DOWN;
      CH_C:     return KEY_RIGHT;
      CH_D:     return KEY_LEFT;
      CH_F:     return KEY_END;
      CH_H:     return KEY_HOME;
      default:  return KEY_UNKN;
    endcase
  endfunction

  // UTF-8 length from the lead pattern, 0 for a byte that cannot lead
  function automatic logic [2:0] utf8_size(input logic [7:0] b);
    casez (b)
      8'b0???????: return 3'd1;
      8'b110?????: return 3'd2;
      8'b1110????: return 3'd3;
      8'b11110???: return 3'd4;
      default:     return 3'd0;
    endcase
  endfunction

  function automatic string describe(input key_event_t e);
    return $sformatf("kind %0d ctrl %b shift %b alt %b bytes %h len %0d",
                     e.kind, e.ctrl, e.shift, e.alt, e.bytes, e.len);
  endfunction

  task automatic note_failure(input string what);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("mismatch %0d: %s", fail_count, what);
  endtask

  // Queue a key event and return the parser to idle
  task automatic owe_event(input key_t kind, input mods_t m, input logic alt,
                           input logic [31:0] bytes, input logic [2:0] len);
    key_event_t e;
    e.kind = kind;
    e.ctrl = m[0];
    e.shift = m[1];
    e.alt = alt;
    e.bytes = bytes;
    e.len = len;
    owed_events.push_back(e);
    parse_pos = MODE_IDLE;
  endtask

  // Advance the shadow parser by one accepted byte
  task automatic decode_byte(input logic [7:0] b);
    key_t k;
    int slot;
    logic [2:0] n;
    case (parse_pos)
      MODE_ESC: begin
        if (b != CH_BRACKET) owe_event(KEY_CHAR, MOD_NONE, 1'b1, {24'd0, b}, 3'd1);
        else parse_pos = MODE_CSI;
      end
      MODE_CSI: begin
        held_mods = MOD_NONE;
        if (b == CH_ONE) begin
          parse_pos = MODE_ONE;
        end else begin
          k = key_of_final(b);
          if (k == KEY_DEL || k == KEY_UNKN) begin
            held_key = k;
            parse_pos = MODE_TILDE;
          end else begin
            owe_event(k, MOD_NONE, 1'b0, 32'd0, 3'd0);
          end
        end
      end
      MODE_ONE: begin
        if (b != CH_SEMI) owe_event(KEY_UNKN, MOD_NONE, 1'b0, 32'd0, 3'd0);
        else parse_pos = MODE_MOD1;
      end
      MODE_MOD1: begin
        held_mods = modifier_of(b);
        parse_pos = MODE_FIN1;
      end
      MODE_FIN1: owe_event(key_of_final(b), held_mods, 1'b0, 32'd0, 3'd0);
      MODE_TILDE: begin
        if (b == CH_SEMI) parse_pos = MODE_TMOD;
        else if (b != CH_TILDE) owe_event(KEY_UNKN, MOD_NONE, 1'b0, 32'd0, 3'd0);
        else owe_event(held_key, MOD_NONE, 1'b0, 32'd0, 3'd0);
      end
      MODE_TMOD: begin
        held_mods = modifier_of(b);
        parse_pos = MODE_TFIN;
      end
      MODE_TFIN: begin
        if (b != CH_TILDE) owe_event(KEY_UNKN, MOD_NONE, 1'b0, 32'd0, 3'd0);
        else owe_event(held_key, held_mods, 1'b0, 32'd0, 3'd0);
      end
      MODE_UTF8: begin
        // continuation bytes fill the tail in arrival order
        slot = (int'(utf8_size_total) - int'(utf8_togo)) & 3;
        if (slot == 0) slot = 1;
        utf8_tail = utf8_tail | ({16'd0, b} << (8 * (slot - 1)));
        utf8_togo = utf8_togo - 2'd1;
        if (utf8_togo == 2'd0)
          owe_event(KEY_CHAR, MOD_NONE, 1'b0, {utf8_tail, utf8_first}, utf8_size_total);
      end
      default: begin
        // idle, or any impossible position
        parse_pos = MODE_IDLE;
        case (b)
          CH_ETX:          owe_event(KEY_INTR, MOD_NONE, 1'b0, 32'd0, 3'd0);
          CH_TAB:          owe_event(KEY_TAB, MOD_NONE, 1'b0, 32'd0, 3'd0);
          CH_LF, CH_CR:    owe_event(KEY_ENTER, MOD_NONE, 1'b0, 32'd0, 3'd0);
          CH_ETB:          owe_event(KEY_BKSP, MOD_CTRL, 1'b0, 32'd0, 3'd0);
          CH_BS, CH_RUBOUT: owe_event(KEY_BKSP, MOD_NONE, 1'b0, 32'd0, 3'd0);
          CH_ESC:          parse_pos = MODE_ESC;
          default: begin
            n = utf8_size(b);
            if (n == 3'd0) begin
              owe_event(KEY_CHAR, MOD_NONE, 1'b0, 32'd0, 3'd0);
            end else if (n == 3'd1) begin
              owe_event(KEY_CHAR, MOD_NONE, 1'b0, {24'd0, b}, 3'd1);
            end else begin
              utf8_first = b;
              utf8_size_total = n;
              utf8_togo = 2'(n - 3'd1);
              utf8_tail = 24'd0;
              parse_pos = MODE_UTF8;
            end
          end
        endcase
      end
    endcase
  endtask

  // Check the output word first: it can only come from an earlier input word
  always @(posedge clk) begin
    if (rst) begin
      parse_pos = MODE_IDLE;
      held_mods = MOD_NONE;
      held_key = KEY_CHAR;
      utf8_tail = 24'd0;
      utf8_first = 8'd0;
      utf8_togo = 2'd0;
      utf8_size_total = 3'd0;
      owed_events.delete();
    end else begin
      if (out_valid && !out_stall) begin
        seen.kind = key_t'(key_kind);
        seen.ctrl = ctrl_flag;
        seen.shift = shift_flag;
        seen.alt = alt_flag;
        seen.bytes = char_bytes;
        seen.len = char_length;
        events_checked++;
        if (owed_events.size() == 0) begin
          note_failure({"key event with none expected: ", describe(seen)});
        end else begin
          want = owed_events.pop_front();
          if (seen !== want)
            note_failure({"expected ", describe(want), ", got ", describe(seen)});
        end
      end
      if (in_valid && !in_stall) decode_byte(in_byte);
    end
    events_owed = owed_events.size();
  end

endmodule

// ===== tb/terminal_key_sequence_decoder_tb.sv =====
// Testbench top for the terminal key sequence decoder: stimulus, back-pressure and verdict.
module terminal_key_sequence_decoder_tb;
  import tkd_pkg::*;

  localparam int RANDOM_BYTES = 1720;
  localparam int SQUEEZE_CYCLES = 100;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  key_kind;
  logic        ctrl_flag;
  logic        shift_flag;
  logic        alt_flag;
  logic [31:0] char_bytes;
  logic [2:0]  char_length;

  int fail_count;
  int events_owed;
  int events_checked;

  logic [7:0] keystroke[$];
  int  bytes_sent = 0;
  int  burst_left = 0;
  bit  calm = 1'b0;
  bit  squeeze_req = 1'b0;
  int  cycle_count = 0;

  always #4 clk = ~clk;

  terminal_key_sequence_decoder dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_byte(in_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .key_kind(key_kind),
    .ctrl_flag(ctrl_flag),
    .shift_flag(shift_flag),
    .alt_flag(alt_flag),
    .char_bytes(char_bytes),
    .char_length(char_length)
  );

  tkd_key_event_monitor events_mon (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_byte(in_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .key_kind(key_kind),
    .ctrl_flag(ctrl_flag),
    .shift_flag(shift_flag),
    .alt_flag(alt_flag),
    .char_bytes(char_bytes),
    .char_length(char_length),
    .fail_count(fail_count),
    .events_owed(events_owed),
    .events_checked(events_checked)
  );

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d events still owed", cycle_count, events_owed);
      $display("FAIL terminal_key_sequence_decoder");
      $finish;
    end
  end

  // Receiver: stall patterns of random length, plus one long hold-off on request
  initial begin : receiver
    int pct;
    int run;
    int i;
    bit squeezed;
    squeezed = 1'b0;
    @(negedge clk);
    forever begin
      if (squeeze_req && !squeezed) begin
        squeezed = 1'b1;
        out_stall <= 1'b1;
        repeat (SQUEEZE_CYCLES) @(negedge clk);
      end else begin
        case ($urandom_range(0, 3))
          0:       pct = 0;
          1:       pct = 25;
          2:       pct = 50;
          default: pct = 85;
        endcase
        run = $urandom_range(4, 40);
        for (i = 0; i < run && !(squeeze_req && !squeezed); i++) begin
          out_stall <= ($urandom_range(0, 99) < pct);
          @(negedge clk);
        end
      end
    end
  end

  // Offer one word, with a random gap at the start of each burst; called at a falling edge
  task automatic put_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = calm ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_queued();
    foreach (keystroke[i]) put_byte(keystroke[i]);
    keystroke.delete();
  endtask

  // Sender pause until every predicted event has come out
  task automatic drain();
    in_valid <= 1'b0;
    while (events_owed != 0) @(negedge clk);
    burst_left = 0;
  endtask

  function automatic logic [7:0] pick_final();
    case ($urandom_range(0, 8))
      0:       return CH_A;
      1:       return CH_B;
      2:       return CH_C;
      3:       return CH_D;
      4:       return CH_F;
      5:       return CH_H;
      6:       return CH_THREE;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_mod();
    case ($urandom_range(0, 3))
      0:       return CH_TWO;
      1:       return CH_FIVE;
      default: return 8'($urandom);
    endcase
  endfunction

  // One random keystroke: mostly well-formed sequences, some broken ones and noise
  task automatic gen_keystroke();
    int pick;
    int n;
    int i;
    logic [7:0] b;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      case ($urandom_range(0, 6))
        0:       b = CH_ETX;
        1:       b = CH_TAB;
        2:       b = CH_LF;
        3:       b = CH_CR;
        4:       b = CH_ETB;
        5:       b = CH_BS;
        default: b = CH_RUBOUT;
      endcase
      keystroke.push_back(b);
    end else if (pick < 25) begin
      keystroke.push_back(8'($urandom_range(32, 126)));
    end else if (pick < 40) begin
      // multibyte character; tail bytes are mostly proper continuations
      n = $urandom_range(2, 4);
      case (n)
        2:       b = 8'hC0 | 8'($urandom_range(0, 31));
        3:       b = 8'hE0 | 8'($urandom_range(0, 15));
        default: b = 8'hF0 | 8'($urandom_range(0, 7));
      endcase
      keystroke.push_back(b);
      for (i = 1; i < n; i++)
        keystroke.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                         : 8'h80 | 8'($urandom_range(0, 63)));
    end else if (pick < 45) begin
      keystroke.push_back($urandom_range(0, 1) ? 8'($urandom_range(128, 191))
                                               : 8'($urandom_range(248, 255)));
    end else if (pick < 53) begin
      // alt character
      b = 8'($urandom);
      if (b == CH_BRACKET) b = CH_A;
      keystroke.push_back(CH_ESC);
      keystroke.push_back(b);
    end else if (pick < 65) begin
      keystroke.push_back(CH_ESC);
      keystroke.push_back(CH_BRACKET);
      keystroke.push_back(pick_final());
    end else if (pick < 77) begin
      keystroke.push_back(CH_ESC);
      keystroke.push_back(CH_BRACKET);
      keystroke.push_back(CH_ONE);
      keystroke.push_back(CH_SEMI);
      keystroke.push_back(pick_mod());
      keystroke.push_back(pick_final());
    end else if (pick < 89) begin
      // digit form with optional modifier, closed by a tilde
      keystroke.push_back(CH_ESC);
      keystroke.push_back(CH_BRACKET);
      keystroke.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom) : CH_THREE);
      if ($urandom_range(0, 1)) begin
        keystroke.push_back(CH_SEMI);
        keystroke.push_back(pick_mod());
      end
      keystroke.push_back(CH_TILDE);
    end else if (pick < 95) begin
      keystroke.push_back(CH_ESC);
      keystroke.push_back(CH_BRACKET);
      b = 8'($urandom);
      case ($urandom_range(0, 3))
        0: begin
          // bad separator after the one
          if (b == CH_SEMI) b = CH_A;
          keystroke.push_back(CH_ONE);
          keystroke.push_back(b);
        end
        1: begin
          // modifier present but no closing tilde
          if (b == CH_TILDE) b = CH_A;
          keystroke.push_back(CH_THREE);
          keystroke.push_back(CH_SEMI);
          keystroke.push_back(pick_mod());
          keystroke.push_back(b);
        end
        2: begin
          keystroke.push_back(CH_THREE);
          keystroke.push_back(b);
        end
        default: begin
          // cut short: the next keystroke finishes it
          keystroke.push_back(CH_ONE);
          keystroke.push_back(CH_SEMI);
          keystroke.push_back(pick_mod());
        end
      endcase
    end else begin
      n = $urandom_range(1, 4);
      for (i = 0; i < n; i++) keystroke.push_back(8'($urandom));
    end
    // occasional stretches with no sender gaps
    if ($urandom_range(0, 49) == 0) calm = !calm;
  endtask

  initial begin : stimulus
    int mark;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: control keys, invalid lead, alt, both sequence forms, 4-byte character
    keystroke = '{CH_ETX, CH_TAB, CH_LF, CH_CR, CH_ETB, CH_BS, CH_RUBOUT, 8'hFF,
                  CH_ESC, 8'h80,
                  CH_ESC, CH_BRACKET, CH_ONE, CH_SEMI, CH_TWO, CH_H,
                  CH_ESC, CH_BRACKET, CH_THREE, CH_SEMI, CH_FIVE, CH_TILDE,
                  8'hF0, 8'h9F, 8'h98, 8'h80};
    send_queued();
    drain();

    // Random, first half
    mark = bytes_sent;
    while (bytes_sent < mark + RANDOM_BYTES / 2) begin
      gen_keystroke();
      send_queued();
    end

    // Long receiver hold-off while words keep coming
    calm = 1'b1;
    squeeze_req <= 1'b1;
    mark = bytes_sent;
    while (bytes_sent < mark + 150) begin
      gen_keystroke();
      calm = 1'b1;
      send_queued();
    end
    calm = 1'b0;
    drain();

    // Random, rest
    mark = bytes_sent;
    while (bytes_sent < mark + RANDOM_BYTES / 2) begin
      gen_keystroke();
      send_queued();
    end

    in_valid <= 1'b0;
    while (events_owed != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("Fed %0d bytes and checked %0d key events (%0d failures).",
             bytes_sent, events_checked, fail_count);
    $display("Covered control keys, alt and CSI sequences, UTF-8, broken input, gaps, back-pressure.");
    if (fail_count == 0) begin
      $display("PASS terminal_key_sequence_decoder");
    end else begin
      $display("FAIL terminal_key_sequence_decoder");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/tkd_pkg.sv
hdl/terminal_key_sequence_decoder.sv
hdl/tkd_checker.sv
tb/tkd_key_event_monitor.sv
tb/terminal_key_sequence_decoder_tb.sv
